>>> hdl/btcm_pkg.sv
// btcm_pkg: shared types and constants of the body table collision merge block
`timescale 1ns / 1ps
`default_nettype none
package btcm_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int IDX_W           = 6;
  localparam logic [15:0] MIN_SEP_RESET = 16'd66;
  localparam logic [31:0] SIGN_FLIP     = 32'h8000_0000;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_RUN    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]       mass;
    logic [31:0]       radius;
    logic [IDX_W-1:0]  body_index;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic [31:0]       out_mass;
    logic [31:0]       out_radius;
    logic [IDX_W-1:0]  out_index;
    logic              last;
    logic              is_ack;
    logic              accepted;
  } out_t;

  // one table entry as held in the body memory
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] m;
    logic [31:0] r;
  } body_t;

endpackage
`default_nettype wire

>>> hdl/body_table_collision_merge.sv
// body_table_collision_merge: body table with pairwise merge pass on one shared multiplier
//
//  channel | signals                       | direction | note
//  in      | in_valid in_ready in_data     | input     | load, run or remove request
//  out     | out_valid out_ready out_data  | output    | acks and surviving bodies
//  cfg     | cfg_we cfg_wdata              | input     | min_separation, no wait
//
// a load or a refused remove is answered by an ack; an accepted remove first shifts the
// entries above it left, then acks. a run tests every live pair and merges each colliding
// one (three 66-step divides and a 32-step cube root, all on the single 33x33 multiplier
// and a bit-serial divider), then compacts the live bodies and emits them.
// reset is synchronous and empties the table; no clearing pass is needed.
// in_ready is high only while the sequencer is idle; a stalled out holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module body_table_collision_merge
  import btcm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  wire         out_ready,
  output out_t        out_data,
  input  wire         cfg_we,
  input  wire [15:0]  cfg_wdata
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_ACK    = 6'd1;
  localparam logic [5:0] S_REM_RD = 6'd2;
  localparam logic [5:0] S_REM_WR = 6'd3;
  localparam logic [5:0] S_MS     = 6'd4;
  localparam logic [5:0] S_MS2    = 6'd5;
  localparam logic [5:0] S_I      = 6'd6;
  localparam logic [5:0] S_I_RD   = 6'd7;
  localparam logic [5:0] S_J      = 6'd8;
  localparam logic [5:0] S_J_RD   = 6'd9;
  localparam logic [5:0] S_DX     = 6'd10;
  localparam logic [5:0] S_DY     = 6'd11;
  localparam logic [5:0] S_DZ     = 6'd12;
  localparam logic [5:0] S_RS     = 6'd13;
  localparam logic [5:0] S_CMP    = 6'd14;
  localparam logic [5:0] S_MTOT   = 6'd15;
  localparam logic [5:0] S_V0     = 6'd16;
  localparam logic [5:0] S_V1     = 6'd17;
  localparam logic [5:0] S_V2     = 6'd18;
  localparam logic [5:0] S_DIV    = 6'd19;
  localparam logic [5:0] S_CB0    = 6'd20;
  localparam logic [5:0] S_CB1    = 6'd21;
  localparam logic [5:0] S_CB2    = 6'd22;
  localparam logic [5:0] S_CB3    = 6'd23;
  localparam logic [5:0] S_MWR    = 6'd24;
  localparam logic [5:0] S_C_RD   = 6'd25;
  localparam logic [5:0] S_C_WR   = 6'd26;
  localparam logic [5:0] S_E_RD   = 6'd27;
  localparam logic [5:0] S_E_LD   = 6'd28;

  localparam logic [1:0] CM_A    = 2'd0;
  localparam logic [1:0] CM_B    = 2'd1;
  localparam logic [1:0] CM_ROOT = 2'd2;

  localparam logic [6:0] DIV_LAST = 7'd65;

  logic [5:0]    state;
  logic [CW-1:0] count;
  logic [15:0]   min_sep;
  out_t          out_q;
  logic          ack_ok;

  body_t         mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] alive;
  body_t         rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  body_t         wdata;

  logic [CW-1:0] i, j, k, w;
  body_t         a, b;
  logic          swp;
  logic [CW-1:0] abs_idx, vic_idx;

  logic [32:0]   mul_a, mul_b;
  logic [65:0]   p;
  logic [67:0]   acc;
  logic [31:0]   ms2;
  logic [32:0]   tot;
  logic [1:0]    axis;
  logic [65:0]   num;
  logic [32:0]   rem;
  logic [31:0]   q;
  logic [6:0]    dcnt;
  logic [31:0]   cx, c, sqhi;
  logic [63:0]   cacc;
  logic [96:0]   s;
  logic [4:0]    bitn;
  logic [1:0]    cmode;

  // arithmetic helpers
  logic [32:0] dx, dy, dz, mag_x, mag_y, mag_z, rsum;
  logic [31:0] av, bv, qbit_word, c_new;
  logic [95:0] cube;
  logic [33:0] r2;
  logic        ge;
  logic        out_free;
  logic [CW-1:0] kp1;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    dx    = {b.px[31], b.px} - {a.px[31], a.px};
    dy    = {b.py[31], b.py} - {a.py[31], a.py};
    dz    = {b.pz[31], b.pz} - {a.pz[31], a.pz};
    mag_x = dx[32] ? (33'd0 - dx) : dx;
    mag_y = dy[32] ? (33'd0 - dy) : dy;
    mag_z = dz[32] ? (33'd0 - dz) : dz;
    rsum  = {1'b0, a.r} + {1'b0, b.r};
    unique case (axis)
      2'd0:    begin av = a.vx; bv = b.vx; end
      2'd1:    begin av = a.vy; bv = b.vy; end
      default: begin av = a.vz; bv = b.vz; end
    endcase
    cube  = 96'(cacc) + {p[63:0], 32'd0};
    r2    = {rem, num[65]};
    ge    = r2 >= {1'b0, tot};
    qbit_word = {q[30:0], ge} ^ SIGN_FLIP;
    c_new = (s < 97'(cube)) ? c : cx;
    kp1   = k + CW'(1);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MS:    begin mul_a = 33'(min_sep); mul_b = 33'(min_sep); end
      S_DX:    begin mul_a = mag_x; mul_b = mag_x; end
      S_DY:    begin mul_a = mag_y; mul_b = mag_y; end
      S_DZ:    begin mul_a = mag_z; mul_b = mag_z; end
      S_RS:    begin mul_a = rsum; mul_b = rsum; end
      S_V0:    begin mul_a = {1'b0, a.m}; mul_b = {1'b0, av ^ SIGN_FLIP}; end
      S_V1:    begin mul_a = {1'b0, b.m}; mul_b = {1'b0, bv ^ SIGN_FLIP}; end
      S_CB0:   begin mul_a = {1'b0, cx}; mul_b = {1'b0, cx}; end
      S_CB1:   begin mul_a = {1'b0, p[31:0]}; mul_b = {1'b0, cx}; end
      S_CB2:   begin mul_a = {1'b0, sqhi}; mul_b = {1'b0, cx}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // memory address and write select
  always_comb begin
    raddr = k[AW-1:0];
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = a;
    unique case (state)
      S_IDLE: begin
        we    = in_valid && in_data.req_type == REQ_LOAD && count < MAX_CNT;
        waddr = count[AW-1:0];
        wdata = '{px: in_data.pos_x, py: in_data.pos_y, pz: in_data.pos_z,
                  vx: in_data.vel_x, vy: in_data.vel_y, vz: in_data.vel_z,
                  m: in_data.mass, r: in_data.radius};
      end
      S_REM_RD: raddr = kp1[AW-1:0];
      S_REM_WR: begin we = 1'b1; waddr = k[AW-1:0]; wdata = rdata; end
      S_I:      raddr = i[AW-1:0];
      S_J:      raddr = j[AW-1:0];
      S_MWR:    begin we = 1'b1; waddr = abs_idx[AW-1:0]; wdata = a; end
      S_C_WR:   begin we = 1'b1; waddr = w[AW-1:0]; wdata = rdata; end
      default:  raddr = k[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
    p     <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      min_sep   <= MIN_SEP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_sep <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            priority case (in_data.req_type)
              REQ_LOAD: begin
                ack_ok <= count < MAX_CNT;
                if (count < MAX_CNT) begin
                  alive[count[AW-1:0]] <= 1'b1;
                  count <= count + CW'(1);
                end
                state <= S_ACK;
              end
              REQ_RUN: state <= S_MS;
              REQ_REMOVE: begin
                if (CW'(in_data.body_index) < count && {1'b0, in_data.body_index} < 7'(MAX_ENTRIES)) begin
                  k     <= CW'(in_data.body_index);
                  state <= S_REM_RD;
                end else begin
                  ack_ok <= 1'b0;
                  state  <= S_ACK;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ACK: begin
          if (out_free) begin
            out_q     <= '{out_pos_x: '0, out_pos_y: '0, out_pos_z: '0,
                           out_vel_x: '0, out_vel_y: '0, out_vel_z: '0,
                           out_mass: '0, out_radius: '0, out_index: '0,
                           last: 1'b1, is_ack: 1'b1, accepted: ack_ok};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_REM_RD: begin
          if (kp1 < count) begin
            state <= S_REM_WR;
          end else begin
            count  <= count - CW'(1);
            ack_ok <= 1'b1;
            state  <= S_ACK;
          end
        end
        S_REM_WR: begin
          alive[k[AW-1:0]] <= alive[kp1[AW-1:0]];
          k     <= kp1;
          state <= S_REM_RD;
        end
        S_MS: state <= S_MS2;
        S_MS2: begin
          ms2   <= p[31:0];
          i     <= '0;
          state <= S_I;
        end
        S_I: begin
          if (i >= count) begin
            w     <= '0;
            k     <= '0;
            state <= S_C_RD;
          end else if (!alive[i[AW-1:0]]) begin
            i <= i + CW'(1);
          end else begin
            state <= S_I_RD;
          end
        end
        S_I_RD: begin
          a     <= rdata;
          j     <= i + CW'(1);
          state <= S_J;
        end
        S_J: begin
          if (j >= count) begin
            i     <= i + CW'(1);
            state <= S_I;
          end else if (!alive[j[AW-1:0]]) begin
            j <= j + CW'(1);
          end else begin
            state <= S_J_RD;
          end
        end
        S_J_RD: begin
          b     <= rdata;
          state <= S_DX;
        end
        S_DX: state <= S_DY;
        S_DY: begin
          acc   <= 68'(p);
          state <= S_DZ;
        end
        S_DZ: begin
          acc   <= acc + 68'(p);
          state <= S_RS;
        end
        S_RS: begin
          acc   <= acc + 68'(p);
          state <= S_CMP;
        end
        S_CMP: begin
          // p now holds the squared radius sum
          if (acc < 68'(p) && 68'(ms2) < acc) begin
            tot <= {1'b0, a.m} + {1'b0, b.m};
            if (a.m < b.m) begin
              swp     <= 1'b1;
              a       <= b;
              b       <= a;
              abs_idx <= j;
              vic_idx <= i;
            end else begin
              swp     <= 1'b0;
              abs_idx <= i;
              vic_idx <= j;
            end
            state <= S_MTOT;
          end else begin
            j     <= j + CW'(1);
            state <= S_J;
          end
        end
        S_MTOT: begin
          if (tot != '0) begin
            axis  <= 2'd0;
            state <= S_V0;
          end else begin
            cx    <= a.r;
            cmode <= CM_A;
            state <= S_CB0;
          end
        end
        S_V0: state <= S_V1;
        S_V1: begin
          acc   <= 68'(p);
          state <= S_V2;
        end
        S_V2: begin
          num   <= acc[65:0] + p;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit per cycle, restoring
          rem  <= ge ? 33'(r2 - {1'b0, tot}) : r2[32:0];
          num  <= {num[64:0], 1'b0};
          q    <= {q[30:0], ge};
          dcnt <= dcnt + 7'd1;
          if (dcnt == DIV_LAST) begin
            unique case (axis)
              2'd0:    a.vx <= qbit_word;
              2'd1:    a.vy <= qbit_word;
              default: a.vz <= qbit_word;
            endcase
            if (axis == 2'd2) begin
              cx    <= a.r;
              cmode <= CM_A;
              state <= S_CB0;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_V0;
            end
          end
        end
        S_CB0: state <= S_CB1;
        S_CB1: begin
          sqhi  <= p[63:32];
          state <= S_CB2;
        end
        S_CB2: begin
          cacc  <= p[63:0];
          state <= S_CB3;
        end
        S_CB3: begin
          priority case (cmode)
            CM_A: begin
              s     <= 97'(cube);
              cx    <= b.r;
              cmode <= CM_B;
              state <= S_CB0;
            end
            CM_B: begin
              s     <= s + 97'(cube);
              c     <= '0;
              bitn  <= 5'd31;
              cx    <= 32'h8000_0000;
              cmode <= CM_ROOT;
              state <= S_CB0;
            end
            default: begin
              if (bitn == 5'd0) begin
                a.r   <= c_new;
                a.m   <= tot[32] ? 32'hFFFF_FFFF : tot[31:0];
                state <= S_MWR;
              end else begin
                c     <= c_new;
                cx    <= c_new | (32'd1 << (bitn - 5'd1));
                bitn  <= bitn - 5'd1;
                state <= S_CB0;
              end
            end
          endcase
        end
        S_MWR: begin
          alive[vic_idx[AW-1:0]] <= 1'b0;
          if (swp) begin
            i     <= i + CW'(1);
            state <= S_I;
          end else begin
            j     <= j + CW'(1);
            state <= S_J;
          end
        end
        S_C_RD: begin
          if (k >= count) begin
            count <= w;
            k     <= '0;
            state <= (w == '0) ? S_IDLE : S_E_RD;
          end else if (alive[k[AW-1:0]]) begin
            state <= S_C_WR;
          end else begin
            k <= k + CW'(1);
          end
        end
        S_C_WR: begin
          alive[w[AW-1:0]] <= 1'b1;
          w     <= w + CW'(1);
          k     <= k + CW'(1);
          state <= S_C_RD;
        end
        S_E_RD: state <= S_E_LD;
        S_E_LD: begin
          if (out_free) begin
            out_q     <= '{out_pos_x: rdata.px, out_pos_y: rdata.py, out_pos_z: rdata.pz,
                           out_vel_x: rdata.vx, out_vel_y: rdata.vy, out_vel_z: rdata.vz,
                           out_mass: rdata.m, out_radius: rdata.r,
                           out_index: IDX_W'(k[AW-1:0]),
                           last: kp1 == count, is_ack: 1'b0, accepted: 1'b0};
            out_valid <= 1'b1;
            k         <= kp1;
            state     <= (kp1 == count) ? S_IDLE : S_E_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_data = out_q;

  ap_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("body count above table size");

  ap_ack_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_ack |-> out_data.last)
    else $error("ack item without last");

  ap_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> tot != '0)
    else $error("divide with zero mass sum");

  ap_merge_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_MWR |-> abs_idx != vic_idx && abs_idx < count && vic_idx < count)
    else $error("merge write with bad pair");

  ap_load_ack: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && in_valid && in_data.req_type == REQ_LOAD |=> state == S_ACK)
    else $error("load not followed by ack");

endmodule
`default_nettype wire

>>> tb/tb_body_table_collision_merge.sv
// tb_body_table_collision_merge: self-checking testbench for the body table collision merge block
`timescale 1ns / 1ps
module tb_body_table_collision_merge;
  import btcm_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int WATCH_LIMIT = 200000;
  localparam int SETTLE_CYC  = 200;

  typedef enum logic [1:0] {CHK_MODEL, CHK_ACK_OK, CHK_ACK_REFUSED} chk_e;
  typedef struct {
    in_t  item;
    chk_e chk;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  body_table_collision_merge u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the body table
  logic [31:0] tb_px[TABLE_DEPTH], tb_py[TABLE_DEPTH], tb_pz[TABLE_DEPTH];
  logic [31:0] tb_vx[TABLE_DEPTH], tb_vy[TABLE_DEPTH], tb_vz[TABLE_DEPTH];
  logic [31:0] tb_mass[TABLE_DEPTH], tb_rad[TABLE_DEPTH];
  bit          tb_alive[TABLE_DEPTH];
  int          tb_count = 0;
  logic [15:0] tb_min_sep = MIN_SEP_RESET;

  out_t bodies_due[$];
  int   err_cnt = 0;
  int   items_sent = 0, results_seen = 0, merges_seen = 0, runs_sent = 0;
  int   out_hold = 0;
  bit   quiet = 1'b0;

  function automatic logic [127:0] sq_gap(logic [31:0] a, logic [31:0] b);
    longint d;
    logic [127:0] m;
    d = longint'($signed(b)) - longint'($signed(a));
    if (d < 0) d = -d;
    m = 128'(d);
    return m * m;
  endfunction

  function automatic logic [31:0] mass_mean(logic [31:0] ma, logic [31:0] va,
                                            logic [31:0] mb, logic [31:0] vb,
                                            logic [127:0] tot);
    logic [127:0] num, q;
    num = 128'(ma) * 128'(va ^ SIGN_FLIP) + 128'(mb) * 128'(vb ^ SIGN_FLIP);
    q = num / tot;
    return q[31:0] ^ SIGN_FLIP;
  endfunction

  function automatic logic [31:0] cube_root(logic [31:0] ra, logic [31:0] rb);
    logic [127:0] s, t;
    logic [31:0] c;
    c = '0;
    s = 128'(ra) * 128'(ra) * 128'(ra) + 128'(rb) * 128'(rb) * 128'(rb);
    for (int b = 31; b >= 0; b--) begin
      t = 128'(c | (32'd1 << b));
      if (!(s < t * t * t)) c = c | (32'd1 << b);
    end
    return c;
  endfunction

  function automatic void absorb(int a, int v);
    logic [127:0] tot;
    tot = 128'(tb_mass[a]) + 128'(tb_mass[v]);
    if (tot != 0) begin
      tb_vx[a] = mass_mean(tb_mass[a], tb_vx[a], tb_mass[v], tb_vx[v], tot);
      tb_vy[a] = mass_mean(tb_mass[a], tb_vy[a], tb_mass[v], tb_vy[v], tot);
      tb_vz[a] = mass_mean(tb_mass[a], tb_vz[a], tb_mass[v], tb_vz[v], tot);
    end
    tb_mass[a] = (tot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot[31:0];
    tb_rad[a] = cube_root(tb_rad[a], tb_rad[v]);
    tb_alive[v] = 1'b0;
    merges_seen++;
  endfunction

  function automatic void move_entry(int d, int s);
    tb_px[d] = tb_px[s]; tb_py[d] = tb_py[s]; tb_pz[d] = tb_pz[s];
    tb_vx[d] = tb_vx[s]; tb_vy[d] = tb_vy[s]; tb_vz[d] = tb_vz[s];
    tb_mass[d] = tb_mass[s]; tb_rad[d] = tb_rad[s]; tb_alive[d] = tb_alive[s];
  endfunction

  function automatic out_t ack_item(bit ok);
    out_t o;
    o = '0;
    o.last = 1'b1;
    o.is_ack = 1'b1;
    o.accepted = ok;
    return o;
  endfunction

  // advances the shadow table by one request and returns the acks and bodies it emits
  function automatic void step_table(in_t it, ref out_t res[$]);
    logic [127:0] ms2, d2, rs2;
    int w;
    out_t o;
    res.delete();
    if (it.req_type == REQ_LOAD) begin
      if (tb_count < TABLE_DEPTH) begin
        tb_px[tb_count] = it.pos_x; tb_py[tb_count] = it.pos_y; tb_pz[tb_count] = it.pos_z;
        tb_vx[tb_count] = it.vel_x; tb_vy[tb_count] = it.vel_y; tb_vz[tb_count] = it.vel_z;
        tb_mass[tb_count] = it.mass; tb_rad[tb_count] = it.radius;
        tb_alive[tb_count] = 1'b1;
        tb_count++;
        res.push_back(ack_item(1'b1));
      end else begin
        res.push_back(ack_item(1'b0));
      end
    end else if (it.req_type == REQ_REMOVE) begin
      if (int'(it.body_index) < tb_count) begin
        for (int i = it.body_index; i + 1 < tb_count; i++) move_entry(i, i + 1);
        tb_count--;
        res.push_back(ack_item(1'b1));
      end else begin
        res.push_back(ack_item(1'b0));
      end
    end else if (it.req_type == REQ_RUN) begin
      ms2 = 128'(tb_min_sep) * 128'(tb_min_sep);
      for (int i = 0; i < tb_count; i++) begin
        for (int j = i + 1; j < tb_count && tb_alive[i]; j++) begin
          if (!tb_alive[j]) continue;
          d2 = sq_gap(tb_px[i], tb_px[j]) + sq_gap(tb_py[i], tb_py[j]) +
               sq_gap(tb_pz[i], tb_pz[j]);
          rs2 = (128'(tb_rad[i]) + 128'(tb_rad[j])) * (128'(tb_rad[i]) + 128'(tb_rad[j]));
          if (d2 < rs2 && ms2 < d2) begin
            // ties go to the lower index
            if (tb_mass[i] >= tb_mass[j]) absorb(i, j);
            else absorb(j, i);
          end
        end
      end
      w = 0;
      for (int i = 0; i < tb_count; i++) begin
        if (tb_alive[i]) begin
          if (w != i) move_entry(w, i);
          w++;
        end
      end
      tb_count = w;
      for (int i = 0; i < tb_count; i++) begin
        o.out_pos_x = tb_px[i]; o.out_pos_y = tb_py[i]; o.out_pos_z = tb_pz[i];
        o.out_vel_x = tb_vx[i]; o.out_vel_y = tb_vy[i]; o.out_vel_z = tb_vz[i];
        o.out_mass = tb_mass[i]; o.out_radius = tb_rad[i];
        o.out_index = i[IDX_W-1:0];
        o.last = (i + 1 == tb_count);
        o.is_ack = 1'b0;
        o.accepted = 1'b0;
        res.push_back(o);
      end
    end
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // output side: compare, then draw the next stall
  always @(posedge clk) begin
    out_t w;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (bodies_due.size() == 0) begin
        report("unexpected item", 64'(out_data), 64'd0);
      end else begin
        w = bodies_due.pop_front();
        if (out_data.out_pos_x !== w.out_pos_x) report("pos_x", out_data.out_pos_x, w.out_pos_x);
        if (out_data.out_pos_y !== w.out_pos_y) report("pos_y", out_data.out_pos_y, w.out_pos_y);
        if (out_data.out_pos_z !== w.out_pos_z) report("pos_z", out_data.out_pos_z, w.out_pos_z);
        if (out_data.out_vel_x !== w.out_vel_x) report("vel_x", out_data.out_vel_x, w.out_vel_x);
        if (out_data.out_vel_y !== w.out_vel_y) report("vel_y", out_data.out_vel_y, w.out_vel_y);
        if (out_data.out_vel_z !== w.out_vel_z) report("vel_z", out_data.out_vel_z, w.out_vel_z);
        if (out_data.out_mass !== w.out_mass) report("mass", out_data.out_mass, w.out_mass);
        if (out_data.out_radius !== w.out_radius)
          report("radius", out_data.out_radius, w.out_radius);
        if (out_data.out_index !== w.out_index) report("index", out_data.out_index, w.out_index);
        if (out_data.last !== w.last) report("last", out_data.last, w.last);
        if (out_data.is_ack !== w.is_ack) report("is_ack", out_data.is_ack, w.is_ack);
        if (out_data.accepted !== w.accepted) report("accepted", out_data.accepted, w.accepted);
      end
      out_hold = quiet ? 0 : $urandom_range(0, 15);
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready = 1'b0;
      out_hold--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either side
  int idle_cyc = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WATCH_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(in_t it, chk_e chk);
    out_t res[$];
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    step_table(it, res);
    if (chk == CHK_ACK_OK) bodies_due.push_back(ack_item(1'b1));
    else if (chk == CHK_ACK_REFUSED) bodies_due.push_back(ack_item(1'b0));
    else foreach (res[k]) bodies_due.push_back(res[k]);
    if (it.req_type == REQ_RUN) runs_sent++;
    items_sent++;
  endtask

  // waits for the block to go idle with nothing outstanding
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (bodies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_min_sep(logic [15:0] v);
    drain();
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    tb_min_sep = v;
  endtask

  function automatic in_t body(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                               logic [31:0] m, logic [31:0] r);
    in_t it;
    it = '0;
    it.req_type = REQ_LOAD;
    it.pos_x = px; it.pos_y = py; it.pos_z = pz;
    it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
    it.mass = m; it.radius = r;
    return it;
  endfunction

  function automatic in_t request(logic [1:0] req, logic [IDX_W-1:0] idx);
    in_t it;
    it = '0;
    it.req_type = req;
    it.body_index = idx;
    return it;
  endfunction

  // clustered bodies collide often; wild ones toggle every bit
  function automatic in_t rand_body(bit wild);
    in_t it;
    it = body($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (!wild) begin
      it.pos_x = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.pos_y = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.pos_z = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      it.radius = $urandom_range(0, 32'h0002_0000);
      case ($urandom_range(0, 3))
        0: it.mass = 32'd0;
        1: it.mass = $urandom_range(0, 32'h0001_0000);
        default: it.mass = $urandom;
      endcase
    end
    it.body_index = IDX_W'($urandom);
    return it;
  endfunction

  row_t plan[$];

  initial begin
    int kind;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    plan.push_back('{request(REQ_RUN, '0), CHK_MODEL});
    plan.push_back('{request(REQ_REMOVE, '0), CHK_ACK_REFUSED});
    plan.push_back('{request(2'd3, '1), CHK_MODEL});
    plan.push_back('{body(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, '1, '1), CHK_ACK_OK});
    plan.push_back('{body(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, '1, '1), CHK_ACK_OK});
    plan.push_back('{request(REQ_RUN, '0), CHK_MODEL});
    plan.push_back('{request(REQ_REMOVE, 6'd63), CHK_ACK_REFUSED});
    plan.push_back('{request(REQ_REMOVE, 6'd0), CHK_ACK_OK});
    // equal masses, overlapping: the lower index absorbs
    plan.push_back('{body(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000,
                          32'h0001_0000), CHK_ACK_OK});
    plan.push_back('{body(32'h0001_8000, 0, 0, 32'hFFFE_0000, 0, 0, 32'h0001_0000,
                          32'h0001_0000), CHK_ACK_OK});
    // heavier later body absorbs the earlier one
    plan.push_back('{body(0, 32'h0010_0000, 0, 32'h0000_1000, 0, 0, 32'h0000_1000,
                          32'h0000_8000), CHK_ACK_OK});
    plan.push_back('{body(0, 32'h0010_4000, 0, 0, 32'h0000_1000, 0, 32'h0009_0000,
                          32'h0000_8000), CHK_ACK_OK});
    // both massless: absorber keeps its velocity
    plan.push_back('{body(0, 0, 32'h0020_0000, 32'h1234_0000, 0, 0, 0, 32'h0001_0000),
                     CHK_ACK_OK});
    plan.push_back('{body(0, 0, 32'h0020_2000, 32'hCDEF_0000, 0, 0, 0, 32'h0001_0000),
                     CHK_ACK_OK});
    // coincident pair: not above min separation, never merged
    plan.push_back('{body(32'h0030_0000, 0, 0, 0, 0, 0, 32'h5, 32'h0001_0000), CHK_ACK_OK});
    plan.push_back('{body(32'h0030_0000, 0, 0, 0, 0, 0, 32'h7, 32'h0001_0000), CHK_ACK_OK});
    // two saturating masses
    plan.push_back('{body(0, 32'h0040_0000, 0, 32'h7FFF_FFFF, 0, 0, '1, 32'h0001_0000),
                     CHK_ACK_OK});
    plan.push_back('{body(0, 32'h0040_1000, 0, 32'h7FFF_FFFF, 0, 0, '1, 32'h0001_0000),
                     CHK_ACK_OK});
    plan.push_back('{request(REQ_RUN, '0), CHK_MODEL});
    plan.push_back('{request(REQ_REMOVE, 6'd1), CHK_MODEL});
    plan.push_back('{request(REQ_RUN, '0), CHK_MODEL});
    foreach (plan[k]) send(plan[k].item, plan[k].chk);

    write_min_sep(16'hFFFF);
    send(request(REQ_RUN, '0), CHK_MODEL);
    write_min_sep(16'h0000);

    // random part: batches of loads followed by a run, with removes and noise
    while (items_sent < 240) begin
      quiet = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 8)) send(rand_body($urandom_range(0, 9) == 0), CHK_MODEL);
      if ($urandom_range(0, 3) == 0)
        send(request(REQ_REMOVE,
                     $urandom_range(0, 3) == 0 ? IDX_W'($urandom) : IDX_W'(tb_count / 2)),
             CHK_MODEL);
      if ($urandom_range(0, 9) == 0) send(request(2'd3, IDX_W'($urandom)), CHK_MODEL);
      send(request(REQ_RUN, '0), CHK_MODEL);
      while (tb_count > 16)
        send(request(REQ_REMOVE, IDX_W'($urandom_range(0, tb_count - 1))), CHK_MODEL);
      kind = $urandom_range(0, 7);
      if (kind == 0) write_min_sep(16'($urandom));
      else if (kind == 1) write_min_sep(kind[0] ? 16'hFFFF : MIN_SEP_RESET);
      else if (kind == 2) drain();
    end

    // fill the table to the brim, one refused load, then a remove and a run
    quiet = 1'b0;
    while (tb_count < TABLE_DEPTH) send(rand_body($urandom_range(0, 1)), CHK_MODEL);
    send(rand_body(1'b0), CHK_ACK_REFUSED);
    send(request(REQ_REMOVE, 6'd63), CHK_MODEL);
    send(request(REQ_RUN, '0), CHK_MODEL);

    drain();
    $display("sent %0d requests (%0d runs), checked %0d items, %0d merges predicted",
             items_sent, runs_sent, results_seen, merges_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> body_table_collision_merge.f
hdl/btcm_pkg.sv
hdl/body_table_collision_merge.sv
tb/tb_body_table_collision_merge.sv
